// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the escaper RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/cbhe_pkg.sv =====
// Shared types and constants of the control byte hex escaper.
// Depends on nothing; used by the planner, the emitter and the top level.
`timescale 1ns / 1ps
`default_nettype none

package cbhe_pkg;

   localparam int unsigned CapWidth   = 16;
   localparam int unsigned CountWidth = 4;   // up to 13 results per word

   localparam logic [39:0] OPEN_TAG  = "<hex>";
   localparam logic [47:0] CLOSE_TAG = "</hex>";

   localparam logic [CountWidth-1:0] OPEN_LEN  = 4'd5;
   localparam logic [CountWidth-1:0] CLOSE_LEN = 4'd6;

   // Text written ahead of the byte itself
   typedef enum logic [1:0] {
      PRE_NONE,
      PRE_OPEN,
      PRE_CLOSE
   } pre_type;

   // How the byte itself is written
   typedef enum logic [1:0] {
      BODY_NONE,
      BODY_HEX,
      BODY_RAW
   } body_type;

   // Everything the emitter needs to spell out one word's results
   typedef struct packed {
      logic [7:0]            data_byte;
      pre_type               pre;
      body_type              body;
      logic                  post_close;
      logic                  overflow;
      logic [CountWidth-1:0] count;
   } plan_type;

endpackage

`default_nettype wire

// ===== rtl/core/control_byte_hex_escaper.sv =====
// Control byte hex escaper: a printable byte leaves as one result word and
// the input takes a new byte every cycle while results are not stalled. A
// word that opens or closes a <hex> run, is written as two hex digits or
// overflows produces up to 13 result words, and the input stalls until its
// last result goes out: one emitter sends one character per cycle and the
// next word is taken in the cycle its last character goes out; result
// stalls add to this. Words of a failed field produce nothing and are taken
// once the emitter holds no pending word. The user must write the capacity
// register only while the block is idle; the block does not enforce this.
// Depends on cbhe_pkg, cbhe_plan, cbhe_emit and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module control_byte_hex_escaper (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [cbhe_pkg::CapWidth-1:0] csr_wr_data,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [7:0]                    req_data_byte,
   input  wire logic                          req_is_last,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [7:0]                         rsp_out_char,
   output logic                               rsp_run_end,
   output logic                               rsp_overflow
);

   cbhe_pkg::plan_type plan;
   logic               has_results;
   logic               plan_ready;
   logic               plan_busy;
   logic               req_accept;

   // Accept a word whenever the plan slot frees up
   assign req_stall  = !plan_ready;
   assign req_accept = req_valid && !req_stall;

   cbhe_plan u_plan (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (req_accept),
      .data_byte   (req_data_byte),
      .is_last     (req_is_last),
      .plan        (plan),
      .has_results (has_results)
   );

   cbhe_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .plan_load    (req_accept && has_results),
      .plan_in      (plan),
      .plan_ready   (plan_ready),
      .plan_busy    (plan_busy),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_run_end  (rsp_run_end),
      .rsp_overflow (rsp_overflow)
   );

   `ASSERT_IMPLIES(a_ovf_ends_word, clock, reset, rsp_valid && rsp_overflow,
                   rsp_run_end && (rsp_out_char == 8'h00))
   `ASSERT_NEXT(a_load_fills_plan, clock, reset, req_accept && has_results, plan_busy)
   `ASSERT_NEXT(a_run_continues, clock, reset, rsp_valid && !rsp_stall && !rsp_run_end, rsp_valid)

endmodule

`default_nettype wire

// ===== rtl/core/cbhe_plan.sv =====
// Planner: field state, capacity register and the per-word output plan.
// Depends on cbhe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbhe_plan (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [cbhe_pkg::CapWidth-1:0] csr_wr_data,
   input  wire logic                          accept,
   input  wire logic [7:0]                    data_byte,
   input  wire logic                          is_last,
   output cbhe_pkg::plan_type                 plan,
   output logic                               has_results
);

   logic [cbhe_pkg::CapWidth-1:0] capacity_ff;
   logic [cbhe_pkg::CapWidth-1:0] bytes_written_ff, bytes_written_in;
   logic                          in_hex_ff, in_hex_in;
   logic                          failed_ff, failed_in;

   logic                            is_ctrl;
   logic                            hex_next;
   logic                            ovf;
   logic [cbhe_pkg::CountWidth-1:0] base;
   logic [cbhe_pkg::CountWidth-1:0] pre_len;
   logic [cbhe_pkg::CountWidth-1:0] body_len;
   logic [cbhe_pkg::CountWidth-1:0] post_len;
   logic [cbhe_pkg::CountWidth-1:0] advance;

   // True when len more characters still fit in the field
   function automatic logic fits(input logic [cbhe_pkg::CapWidth-1:0]   written,
                                 input logic [cbhe_pkg::CapWidth-1:0]   cap,
                                 input logic [cbhe_pkg::CountWidth-1:0] len);
      logic [cbhe_pkg::CapWidth:0] need;
      need = {1'b0, written} + (cbhe_pkg::CapWidth+1)'(len);
      return need <= {1'b0, cap};
   endfunction

   // Decide the text for this word from the field state
   always_comb begin
      is_ctrl       = (data_byte[6:5] == 2'b00);
      hex_next      = in_hex_ff;
      ovf           = 1'b0;
      base          = '0;
      plan.data_byte  = data_byte;
      plan.pre        = cbhe_pkg::PRE_NONE;
      plan.body       = cbhe_pkg::BODY_NONE;
      plan.post_close = 1'b0;
      if (is_ctrl) begin
         base = in_hex_ff ? 4'd0 : cbhe_pkg::OPEN_LEN;
         if (!in_hex_ff && !fits(bytes_written_ff, capacity_ff, cbhe_pkg::OPEN_LEN)) begin
            ovf = 1'b1;
         end else begin
            if (!in_hex_ff) begin
               plan.pre = cbhe_pkg::PRE_OPEN;
            end
            hex_next = 1'b1;
            if (!fits(bytes_written_ff, capacity_ff, base + 4'd2)) begin
               ovf = 1'b1;
            end else begin
               plan.body = cbhe_pkg::BODY_HEX;
               if (is_last) begin
                  if (fits(bytes_written_ff, capacity_ff,
                           base + 4'd2 + cbhe_pkg::CLOSE_LEN)) begin
                     plan.post_close = 1'b1;
                  end else begin
                     ovf = 1'b1;
                  end
               end
            end
         end
      end else begin
         base = in_hex_ff ? cbhe_pkg::CLOSE_LEN : 4'd0;
         if (in_hex_ff && !fits(bytes_written_ff, capacity_ff, cbhe_pkg::CLOSE_LEN)) begin
            ovf = 1'b1;
         end else begin
            if (in_hex_ff) begin
               plan.pre = cbhe_pkg::PRE_CLOSE;
            end
            hex_next = 1'b0;
            if (!fits(bytes_written_ff, capacity_ff, base + 4'd1)) begin
               ovf = 1'b1;
            end else begin
               plan.body = cbhe_pkg::BODY_RAW;
            end
         end
      end

      case (plan.pre)
         cbhe_pkg::PRE_OPEN:  pre_len = cbhe_pkg::OPEN_LEN;
         cbhe_pkg::PRE_CLOSE: pre_len = cbhe_pkg::CLOSE_LEN;
         default:             pre_len = '0;
      endcase
      case (plan.body)
         cbhe_pkg::BODY_HEX: body_len = 4'd2;
         cbhe_pkg::BODY_RAW: body_len = 4'd1;
         default:            body_len = '0;
      endcase
      post_len      = plan.post_close ? cbhe_pkg::CLOSE_LEN : 4'd0;
      advance       = pre_len + body_len + post_len;
      plan.overflow = ovf;
      plan.count    = advance + {3'b000, ovf};
      has_results   = !failed_ff;
   end

   // Next field state; the last word of a field clears it
   always_comb begin
      bytes_written_in = bytes_written_ff;
      in_hex_in        = in_hex_ff;
      failed_in        = failed_ff;
      if (accept) begin
         if (is_last) begin
            bytes_written_in = '0;
            in_hex_in        = 1'b0;
            failed_in        = 1'b0;
         end else if (!failed_ff) begin
            bytes_written_in = bytes_written_ff + cbhe_pkg::CapWidth'(advance);
            in_hex_in        = hex_next;
            failed_in        = ovf;
         end
      end
   end

   // Hold capacity and field state
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff      <= '1;
         bytes_written_ff <= '0;
         in_hex_ff        <= 1'b0;
         failed_ff        <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         bytes_written_ff <= bytes_written_in;
         in_hex_ff        <= in_hex_in;
         failed_ff        <= failed_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/cbhe_emit.sv =====
// Emitter: plan register, character position counter and result register.
// Depends on cbhe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbhe_emit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               plan_load,
   input  wire cbhe_pkg::plan_type plan_in,
   output logic                    plan_ready,
   output logic                    plan_busy,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_out_char,
   output logic                    rsp_run_end,
   output logic                    rsp_overflow
);

   cbhe_pkg::plan_type              plan_ff, plan_in_sel;
   logic                            plan_valid_ff, plan_valid_in;
   logic [cbhe_pkg::CountWidth-1:0] pos_ff, pos_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [7:0]                      char_ff;
   logic                            run_end_ff;
   logic                            overflow_ff;

   logic                            out_load;
   logic                            emit;
   logic                            last_pos;
   logic [cbhe_pkg::CountWidth-1:0] pre_len;
   logic [cbhe_pkg::CountWidth-1:0] body_len;
   logic [cbhe_pkg::CountWidth-1:0] off_body;
   logic [cbhe_pkg::CountWidth-1:0] off_post;
   logic [7:0]                      cur_char;
   logic                            cur_ovf;

   function automatic logic [7:0] open_char(input logic [2:0] idx);
      return cbhe_pkg::OPEN_TAG[8*(3'd4 - idx) +: 8];
   endfunction

   function automatic logic [7:0] close_char(input logic [2:0] idx);
      return cbhe_pkg::CLOSE_TAG[8*(3'd5 - idx) +: 8];
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      return (nib > 4'd9) ? ({4'h0, nib} + 8'h37) : ({4'h0, nib} + 8'h30);
   endfunction

   // Pick the character at the current position of the plan
   always_comb begin
      case (plan_ff.pre)
         cbhe_pkg::PRE_OPEN:  pre_len = cbhe_pkg::OPEN_LEN;
         cbhe_pkg::PRE_CLOSE: pre_len = cbhe_pkg::CLOSE_LEN;
         default:             pre_len = '0;
      endcase
      case (plan_ff.body)
         cbhe_pkg::BODY_HEX: body_len = 4'd2;
         cbhe_pkg::BODY_RAW: body_len = 4'd1;
         default:            body_len = '0;
      endcase
      off_body = pos_ff - pre_len;
      off_post = off_body - body_len;
      cur_ovf  = 1'b0;
      if (pos_ff < pre_len) begin
         cur_char = (plan_ff.pre == cbhe_pkg::PRE_OPEN) ? open_char(pos_ff[2:0])
                                                        : close_char(pos_ff[2:0]);
      end else if (off_body < body_len) begin
         if (plan_ff.body == cbhe_pkg::BODY_RAW) begin
            cur_char = plan_ff.data_byte;
         end else if (off_body == 4'd0) begin
            cur_char = hex_digit(plan_ff.data_byte[7:4]);
         end else begin
            cur_char = hex_digit(plan_ff.data_byte[3:0]);
         end
      end else if (plan_ff.post_close && (off_post < cbhe_pkg::CLOSE_LEN)) begin
         cur_char = close_char(off_post[2:0]);
      end else begin
         cur_char = 8'h00;
         cur_ovf  = 1'b1;
      end
   end

   // Advance through the plan one character per free output slot
   always_comb begin
      out_load   = !rsp_valid_ff || !rsp_stall;
      emit       = plan_valid_ff && out_load;
      last_pos   = (pos_ff == (plan_ff.count - 4'd1));
      plan_ready = !plan_valid_ff || (emit && last_pos);

      plan_valid_in = plan_valid_ff;
      pos_in        = pos_ff;
      plan_in_sel   = plan_ff;
      if (plan_load) begin
         plan_valid_in = 1'b1;
         pos_in        = '0;
         plan_in_sel   = plan_in;
      end else if (emit) begin
         if (last_pos) begin
            plan_valid_in = 1'b0;
            pos_in        = '0;
         end else begin
            pos_in = pos_ff + 4'd1;
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (out_load) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         plan_valid_ff <= 1'b0;
         pos_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         plan_valid_ff <= plan_valid_in;
         pos_ff        <= pos_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      plan_ff <= plan_in_sel;
      if (emit) begin
         char_ff     <= cur_char;
         run_end_ff  <= last_pos;
         overflow_ff <= cur_ovf;
      end
   end

   assign plan_busy    = plan_valid_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = char_ff;
   assign rsp_run_end  = run_end_ff;
   assign rsp_overflow = overflow_ff;

endmodule

`default_nettype wire
